/* design/tff_pkg.sv */
package tff_pkg;

  // screen and coordinate format
  localparam int MAX_WIDTH     = 128;
  localparam int MAX_HEIGHT    = 128;
  localparam int SUBPIXEL_BITS = 4;

  // command codes
  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_TRIANGLE = 2'd1;
  localparam logic [1:0] CMD_READ     = 2'd2;

  // register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_RED    = 3'd2;
  localparam logic [2:0] REG_GREEN  = 3'd3;
  localparam logic [2:0] REG_BLUE   = 3'd4;

  localparam logic [7:0]  SIZE_RESET  = 8'd128;
  localparam logic [15:0] CLEAR_DEPTH = 16'd25600;  // 100.0 in Q8.8
  localparam logic [7:0]  ALPHA_FF    = 8'hFF;
  localparam logic [14:0] COUNT_MAX   = 15'h7FFF;

  // shared arithmetic unit
  localparam int ACC_W = 64;  // accumulator width, covers every edge and depth sum
  localparam int OPB_W = 18;  // multiplier operand bits, also quotient bits
  localparam int CNT_W = 5;
  localparam int BOX_W = 20;  // bounding box arithmetic

  typedef struct packed {
    logic start;
    logic div;
  } tff_alu_ctl_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] prod;
    logic [OPB_W-1:0] quot;
  } tff_alu_res_t;

endpackage

/* design/tff_req_if.sv */
interface tff_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] ax;
  logic signed [15:0] ay;
  logic signed [15:0] az;
  logic signed [15:0] bx;
  logic signed [15:0] by_coord;
  logic signed [15:0] bz;
  logic signed [15:0] cx;
  logic signed [15:0] cy;
  logic signed [15:0] cz;
  logic [6:0]         read_column;
  logic [6:0]         read_row;

  modport source (output valid, cmd, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                  read_column, read_row, input ready);
  modport sink (input valid, cmd, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                read_column, read_row, output ready);
endinterface

/* design/tff_rsp_if.sv */
interface tff_rsp_if;
  logic               valid;
  logic               ready;
  logic [31:0]        pixel_color;
  logic signed [15:0] pixel_depth;
  logic [14:0]        pixels_written;
  logic               read_outside;

  modport source (output valid, pixel_color, pixel_depth, pixels_written, read_outside,
                  input ready);
  modport sink (input valid, pixel_color, pixel_depth, pixels_written, read_outside,
                output ready);
endinterface

/* design/tff_alu.sv */
module tff_alu
  import tff_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  tff_alu_ctl_t     ctl,
  input  logic [ACC_W-1:0] opnd_a,
  input  logic [ACC_W-1:0] opnd_b,
  output tff_alu_res_t     res
);

  logic             busy;
  logic             div_mode;
  logic [CNT_W-1:0] cnt;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] opa;
  logic [OPB_W-1:0] opb;
  logic             done;
  logic             sub;
  logic             last;
  logic [ACC_W:0]   sum;

  // one adder serves both shift-add multiply and restoring divide
  assign last = (cnt == CNT_W'(OPB_W - 1));
  assign sub  = div_mode || last;
  assign sum  = {1'b0, acc} + {1'b0, (sub ? ~opa : opa)} + (ACC_W+1)'(sub);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (ctl.start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        div_mode <= ctl.div;
        if (ctl.div) begin
          acc <= opnd_a;
          opa <= opnd_b << (OPB_W - 1);
          opb <= '0;
        end else begin
          acc <= '0;
          opa <= opnd_a;
          opb <= opnd_b[OPB_W-1:0];
        end
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (last) busy <= 1'b0;
        if (div_mode) begin
          // quotient bit: remainder at least the shifted divisor
          if (sum[ACC_W]) acc <= sum[ACC_W-1:0];
          opb <= {opb[OPB_W-2:0], sum[ACC_W]};
          opa <= opa >> 1;
        end else begin
          // top multiplier bit carries negative weight
          if (opb[0]) acc <= sum[ACC_W-1:0];
          opb <= opb >> 1;
          opa <= opa << 1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.prod = acc;
  assign res.quot = opb;

endmodule

/* design/triangle_fill_framebuffer.sv */
// Clear: writes the width*height pixels of the screen, one pixel written per cycle.
// Triangle: setup of 13 serial 18-step multiplies on the shared unit, then a scan of
// every pixel of the clipped box, with a serial divide for each covered pixel. Read:
// the stored pixel is fetched unless the position is outside. One command at a time; a
// finished result may wait while the next is taken.
// Synchronous reset clears control and loads register defaults; the stores are not cleared.
module triangle_fill_framebuffer
  import tff_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  logic [7:0] wr_data,
  tff_req_if.sink    req,
  tff_rsp_if.source  rsp
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUB    = 1 << SUBPIXEL_BITS;
  localparam int SH     = SUBPIXEL_BITS + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_MUL = 4'd2;
  localparam logic [3:0] S_BOX = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_DIV = 4'd5;
  localparam logic [3:0] S_READ = 4'd6;
  localparam logic [3:0] S_READ_WAIT = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  // setup multiply steps
  localparam logic [3:0] K_AREA_A = 4'd0;
  localparam logic [3:0] K_AREA_B = 4'd1;
  localparam logic [3:0] K_S_A = 4'd2;
  localparam logic [3:0] K_S_B = 4'd3;
  localparam logic [3:0] K_T_A = 4'd4;
  localparam logic [3:0] K_T_B = 4'd5;
  localparam logic [3:0] K_N_A = 4'd6;
  localparam logic [3:0] K_N_B = 4'd7;
  localparam logic [3:0] K_N_C = 4'd8;
  localparam logic [3:0] K_NV_A = 4'd9;
  localparam logic [3:0] K_NV_B = 4'd10;
  localparam logic [3:0] K_NU_A = 4'd11;
  localparam logic [3:0] K_NU_B = 4'd12;

  logic [3:0] state;
  logic [3:0] k;
  logic       mul_wait;

  logic [7:0] width_reg, height_reg, red_reg, green_reg, blue_reg;
  logic [7:0] w_eff, h_eff;

  logic signed [17:0]       x0, y0, x1, y1, x2, y2;
  logic signed [15:0]       z0, z1, z2;
  logic [6:0]               rcol, rrow;
  logic signed [ACC_W-1:0]  d_area, s, t, n, s_col, t_col, n_col, nu, nv;
  logic                     neg;
  logic [7:0]               umin, umax, vmin, vmax, u, v;
  logic [15:0]              clr;
  logic [14:0]              cnt;
  logic [31:0]              res_color;
  logic [15:0]              res_depth;
  logic                     res_outside;

  logic [23:0]              color_mem [DEPTH];
  logic [15:0]              depth_mem [DEPTH];
  logic [23:0]              rd_color;
  logic [15:0]              rd_depth;

  logic                     out_valid;
  logic [31:0]              out_color;
  logic [15:0]              out_depth;
  logic [14:0]              out_count;
  logic                     out_outside;

  tff_alu_ctl_t             alu_ctl;
  tff_alu_res_t             alu_res;
  logic [ACC_W-1:0]         alu_a, alu_b;
  logic signed [ACC_W-1:0]  mul_a;
  logic signed [17:0]       mul_b;

  logic signed [17:0]       dx1, dy1, dx2, dy2, dz1, dz2;
  logic signed [ACC_W-1:0]  px0, py0, su, tu, sv, tv, st;
  logic signed [17:0]       minx, maxx, miny, maxy;
  logic signed [BOX_W-1:0]  umin_r, umax_r, vmin_r, vmax_r, w_lim, h_lim;
  logic                     box_empty;
  logic [15:0]              wh;
  logic [14:0]              wh_sat;
  logic                     accept, draw, advance, step_col, last_pix;
  logic [7:0]               pc, pr;
  logic [15:0]              paddr;
  logic [ADDR_W-1:0]        mem_addr;
  logic                     mem_we;
  logic [15:0]              depth_q;
  logic [23:0]              fill_word;

  // effective screen size
  assign w_eff = (32'(width_reg) > MAX_WIDTH) ? 8'(MAX_WIDTH) : width_reg;
  assign h_eff = (32'(height_reg) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : height_reg;
  assign wh     = 16'(w_eff) * 16'(h_eff);
  assign wh_sat = (wh > 16'(COUNT_MAX)) ? COUNT_MAX : wh[14:0];
  assign fill_word = {blue_reg, green_reg, red_reg};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= SIZE_RESET;
      height_reg <= SIZE_RESET;
      red_reg    <= '0;
      green_reg  <= '0;
      blue_reg   <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_WIDTH:  width_reg  <= wr_data;
        REG_HEIGHT: height_reg <= wr_data;
        REG_RED:    red_reg    <= wr_data;
        REG_GREEN:  green_reg  <= wr_data;
        REG_BLUE:   blue_reg   <= wr_data;
        default:    ;
      endcase
    end
  end

  // edge deltas
  assign dx1 = x1 - x0;
  assign dy1 = y1 - y0;
  assign dx2 = x2 - x0;
  assign dy2 = y2 - y0;
  assign dz1 = 18'(z1) - 18'(z0);
  assign dz2 = 18'(z2) - 18'(z0);

  // bounding box, shrunk by half a pixel and clipped
  always_comb begin
    minx = x0;
    if (x1 < minx) minx = x1;
    if (x2 < minx) minx = x2;
    maxx = x0;
    if (x1 > maxx) maxx = x1;
    if (x2 > maxx) maxx = x2;
    miny = y0;
    if (y1 < miny) miny = y1;
    if (y2 < miny) miny = y2;
    maxy = y0;
    if (y1 > maxy) maxy = y1;
    if (y2 > maxy) maxy = y2;
    umin_r = (BOX_W'(minx) + BOX_W'(SUB)) >>> SH;
    umax_r = (BOX_W'(maxx) - BOX_W'(SUB)) >>> SH;
    vmin_r = (BOX_W'(miny) + BOX_W'(SUB)) >>> SH;
    vmax_r = (BOX_W'(maxy) - BOX_W'(SUB)) >>> SH;
    w_lim  = $signed({(BOX_W-8)'(0), w_eff}) - BOX_W'(1);
    h_lim  = $signed({(BOX_W-8)'(0), h_eff}) - BOX_W'(1);
    if (umin_r < 0) umin_r = '0;
    if (vmin_r < 0) vmin_r = '0;
    if (umax_r > w_lim) umax_r = w_lim;
    if (vmax_r > h_lim) vmax_r = h_lim;
    box_empty = (umin_r > umax_r) || (vmin_r > vmax_r);
  end

  // start offsets and scan steps
  assign px0 = (ACC_W'({umin, 1'b1}) << SUBPIXEL_BITS) - ACC_W'(x0);
  assign py0 = (ACC_W'({vmin, 1'b1}) << SUBPIXEL_BITS) - ACC_W'(y0);
  assign su  = neg ? (ACC_W'(dy2) <<< SH) : -(ACC_W'(dy2) <<< SH);
  assign tu  = neg ? -(ACC_W'(dy1) <<< SH) : (ACC_W'(dy1) <<< SH);
  assign sv  = neg ? -(ACC_W'(dx2) <<< SH) : (ACC_W'(dx2) <<< SH);
  assign tv  = neg ? (ACC_W'(dx1) <<< SH) : -(ACC_W'(dx1) <<< SH);

  // operand select for setup multiplies
  always_comb begin
    case (k)
      K_AREA_A: begin mul_a = ACC_W'(dy1); mul_b = dx2; end
      K_AREA_B: begin mul_a = ACC_W'(dx1); mul_b = dy2; end
      K_S_A:    begin mul_a = py0;         mul_b = dx2; end
      K_S_B:    begin mul_a = px0;         mul_b = dy2; end
      K_T_A:    begin mul_a = px0;         mul_b = dy1; end
      K_T_B:    begin mul_a = py0;         mul_b = dx1; end
      K_N_A:    begin mul_a = d_area;      mul_b = 18'(z0); end
      K_N_B:    begin mul_a = s;           mul_b = dz1; end
      K_N_C:    begin mul_a = t;           mul_b = dz2; end
      K_NV_A:   begin mul_a = sv;          mul_b = dz1; end
      K_NV_B:   begin mul_a = tv;          mul_b = dz2; end
      K_NU_A:   begin mul_a = su;          mul_b = dz1; end
      K_NU_B:   begin mul_a = tu;          mul_b = dz2; end
      default:  begin mul_a = '0;          mul_b = '0; end
    endcase
  end

  // coverage test at the current pixel
  assign st   = s + t;
  assign draw = !s[ACC_W-1] && !t[ACC_W-1] && (st <= d_area) && !n[ACC_W-1];

  assign alu_ctl.start = ((state == S_MUL) && !mul_wait) || ((state == S_SCAN) && draw);
  assign alu_ctl.div   = (state == S_SCAN);
  assign alu_a = (state == S_SCAN) ? ((n <<< 1) + d_area) : mul_a;
  assign alu_b = (state == S_SCAN) ? (d_area <<< 1) : ACC_W'(mul_b);

  tff_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctl    (alu_ctl),
    .opnd_a (alu_a),
    .opnd_b (alu_b),
    .res    (alu_res)
  );

  assign depth_q = (alu_res.quot[OPB_W-1:15] != '0) ? 16'h7FFF : {1'b0, alu_res.quot[14:0]};

  // scan order: columns outer, rows inner
  assign step_col = (v == vmax);
  assign last_pix = step_col && (u == umax);
  assign advance  = ((state == S_SCAN) && !draw) || ((state == S_DIV) && alu_res.done);

  // row-flipped pixel address
  assign pc       = (state == S_READ) ? {1'b0, rcol} : u;
  assign pr       = (state == S_READ) ? {1'b0, rrow} : v;
  assign paddr    = (16'(h_eff) - 16'd1 - 16'(pr)) * 16'(w_eff) + 16'(pc);
  assign mem_we   = (state == S_CLEAR) || ((state == S_DIV) && alu_res.done);
  assign mem_addr = (state == S_CLEAR) ? ADDR_W'(clr) : ADDR_W'(paddr);

  // pixel stores
  always_ff @(posedge clk) begin
    if (mem_we) begin
      color_mem[mem_addr] <= fill_word;
      depth_mem[mem_addr] <= (state == S_CLEAR) ? CLEAR_DEPTH : depth_q;
    end
    rd_color <= color_mem[mem_addr];
    rd_depth <= depth_mem[mem_addr];
  end

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= K_AREA_A;
      mul_wait  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready && (state != S_DONE)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            x0 <= {req.ax[15], req.ax, 1'b0};
            y0 <= {req.ay[15], req.ay, 1'b0};
            x1 <= {req.bx[15], req.bx, 1'b0};
            y1 <= {req.by_coord[15], req.by_coord, 1'b0};
            x2 <= {req.cx[15], req.cx, 1'b0};
            y2 <= {req.cy[15], req.cy, 1'b0};
            z0 <= req.az;
            z1 <= req.bz;
            z2 <= req.cz;
            rcol        <= req.read_column;
            rrow        <= req.read_row;
            res_color   <= '0;
            res_depth   <= '0;
            res_outside <= 1'b0;
            cnt         <= (req.cmd == CMD_CLEAR) ? wh_sat : '0;
            clr         <= '0;
            k           <= K_AREA_A;
            mul_wait    <= 1'b0;
            case (req.cmd)
              CMD_CLEAR:    state <= (wh == '0) ? S_DONE : S_CLEAR;
              CMD_TRIANGLE: state <= S_MUL;
              CMD_READ:     state <= S_READ;
              default:      state <= S_DONE;
            endcase
          end
        end
        S_CLEAR: begin
          clr <= clr + 16'd1;
          if (clr == wh - 16'd1) state <= S_DONE;
        end
        S_MUL: begin
          if (!mul_wait) begin
            mul_wait <= 1'b1;
          end else if (alu_res.done) begin
            mul_wait <= 1'b0;
            k        <= k + 4'd1;
            case (k)
              K_AREA_A: d_area <= alu_res.prod;
              K_AREA_B: begin
                d_area <= d_area - alu_res.prod;
                state  <= S_BOX;
              end
              K_S_A: s <= alu_res.prod;
              K_S_B: s <= s - alu_res.prod;
              K_T_A: t <= alu_res.prod;
              K_T_B: begin
                s     <= neg ? -s : s;
                s_col <= neg ? -s : s;
                t     <= neg ? -(t - alu_res.prod) : (t - alu_res.prod);
                t_col <= neg ? -(t - alu_res.prod) : (t - alu_res.prod);
              end
              K_N_A: n <= alu_res.prod;
              K_N_B: n <= n + alu_res.prod;
              K_N_C: begin
                n     <= n + alu_res.prod;
                n_col <= n + alu_res.prod;
              end
              K_NV_A: nv <= alu_res.prod;
              K_NV_B: nv <= nv + alu_res.prod;
              K_NU_A: nu <= alu_res.prod;
              K_NU_B: begin
                nu    <= nu + alu_res.prod;
                state <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_BOX: begin
          neg    <= d_area[ACC_W-1];
          d_area <= d_area[ACC_W-1] ? -d_area : d_area;
          umin   <= umin_r[7:0];
          umax   <= umax_r[7:0];
          vmin   <= vmin_r[7:0];
          vmax   <= vmax_r[7:0];
          u      <= umin_r[7:0];
          v      <= vmin_r[7:0];
          state  <= ((d_area == '0) || box_empty) ? S_DONE : S_MUL;
        end
        S_SCAN: begin
          if (draw) state <= S_DIV;
          else if (last_pix) state <= S_DONE;
        end
        S_DIV: begin
          if (alu_res.done) begin
            cnt   <= (cnt == COUNT_MAX) ? cnt : cnt + 15'd1;
            state <= last_pix ? S_DONE : S_SCAN;
          end
        end
        S_READ: begin
          if (({1'b0, rcol} >= w_eff) || ({1'b0, rrow} >= h_eff)) begin
            res_outside <= 1'b1;
            state       <= S_DONE;
          end else begin
            state <= S_READ_WAIT;
          end
        end
        S_READ_WAIT: begin
          res_color <= {ALPHA_FF, rd_color};
          res_depth <= rd_depth;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_color   <= res_color;
            out_depth   <= res_depth;
            out_count   <= cnt;
            out_outside <= res_outside;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // step to the next pixel of the box
      if (advance && !last_pix) begin
        if (step_col) begin
          u     <= u + 8'd1;
          v     <= vmin;
          s_col <= s_col + su;
          t_col <= t_col + tu;
          n_col <= n_col + nu;
          s     <= s_col + su;
          t     <= t_col + tu;
          n     <= n_col + nu;
        end else begin
          v <= v + 8'd1;
          s <= s + sv;
          t <= t + tv;
          n <= n + nv;
        end
      end
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.pixel_color    = out_color;
  assign rsp.pixel_depth    = out_depth;
  assign rsp.pixels_written = out_count;
  assign rsp.read_outside   = out_outside;

endmodule

/* tb/tb.sv */
module tb;
  import tff_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_MAX  = 128;
  localparam int STORE_WORDS = SCREEN_MAX * SCREEN_MAX;
  localparam int SUB         = 16;
  localparam longint CYCLE_LIMIT = 40_000_000;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] ax, ay, az, bx, by_coord, bz, cx, cy, cz;
    logic [6:0]         col, row;
  } draw_cmd_t;

  typedef struct {
    logic [31:0]        color;
    logic signed [15:0] depth;
    logic [14:0]        count;
    logic               outside;
  } pixel_res_t;

  typedef struct {
    draw_cmd_t  c;
    bit         typed;
    pixel_res_t r;
  } stim_row_t;

  logic clk;
  logic rst;
  logic       wr_en;
  logic [2:0] wr_index;
  logic [7:0] wr_data;

  tff_req_if req_ch();
  tff_rsp_if rsp_ch();

  triangle_fill_framebuffer u_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  // framebuffer shadow and register copy
  logic [23:0] shadow_color[STORE_WORDS];
  logic [15:0] shadow_depth[STORE_WORDS];
  logic [7:0]  sh_width, sh_height, sh_red, sh_green, sh_blue;

  pixel_res_t pending_px[$];
  stim_row_t  dir_rows[$];
  int         errors;
  int         hold_len;
  bit         calm;
  longint     cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint eff_w();
    return (sh_width > SCREEN_MAX) ? SCREEN_MAX : longint'(sh_width);
  endfunction

  function automatic longint eff_h();
    return (sh_height > SCREEN_MAX) ? SCREEN_MAX : longint'(sh_height);
  endfunction

  function automatic longint floor_q(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint min3(longint a, longint b, longint c);
    longint m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic longint max3(longint a, longint b, longint c);
    longint m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // rasterise one triangle into the shadow, return pixels written
  function automatic longint raster_tri(draw_cmd_t c);
    longint w, h, x0, y0, z0, x1, y1, z1, x2, y2, z2;
    longint dx1, dy1, dx2, dy2, area, sgn, cnt;
    longint umin, umax, vmin, vmax, px, py, s, t, wa, num, dep, addr;
    w = eff_w(); h = eff_h();
    x0 = 2 * longint'(c.ax); y0 = 2 * longint'(c.ay); z0 = longint'(c.az);
    x1 = 2 * longint'(c.bx); y1 = 2 * longint'(c.by_coord); z1 = longint'(c.bz);
    x2 = 2 * longint'(c.cx); y2 = 2 * longint'(c.cy); z2 = longint'(c.cz);
    dx1 = x1 - x0; dy1 = y1 - y0; dx2 = x2 - x0; dy2 = y2 - y0;
    area = dy1 * dx2 - dx1 * dy2;
    sgn = 1; cnt = 0;
    if (area == 0 || w == 0 || h == 0) return 0;
    if (area < 0) begin
      sgn = -1;
      area = -area;
    end
    umin = floor_q(min3(x0, x1, x2) + SUB, 2 * SUB);
    umax = floor_q(max3(x0, x1, x2) - SUB, 2 * SUB);
    vmin = floor_q(min3(y0, y1, y2) + SUB, 2 * SUB);
    vmax = floor_q(max3(y0, y1, y2) - SUB, 2 * SUB);
    if (umin < 0) umin = 0;
    if (vmin < 0) vmin = 0;
    if (umax > w - 1) umax = w - 1;
    if (vmax > h - 1) vmax = h - 1;
    for (longint u = umin; u <= umax; u++) begin
      for (longint v = vmin; v <= vmax; v++) begin
        px = (2 * u + 1) * SUB - x0;
        py = (2 * v + 1) * SUB - y0;
        s = sgn * (dx2 * py - dy2 * px);
        t = sgn * (dy1 * px - dx1 * py);
        if (s < 0 || t < 0 || s + t > area) continue;
        wa = area - s - t;
        num = z0 * wa + z1 * s + z2 * t;
        if (num < 0) continue;
        dep = floor_q(2 * num + area, 2 * area);
        if (dep > 32767) dep = 32767;
        if (dep < -32768) dep = -32768;
        addr = (h - 1 - v) * w + u;
        shadow_color[addr] = {sh_blue, sh_green, sh_red};
        shadow_depth[addr] = dep[15:0];
        cnt++;
      end
    end
    return cnt;
  endfunction

  // expected result of one command, updating the shadow
  function automatic pixel_res_t fb_apply(draw_cmd_t c);
    pixel_res_t r;
    longint n, addr;
    r = '{default: '0};
    n = 0;
    case (c.cmd)
      CMD_CLEAR: begin
        n = eff_w() * eff_h();
        for (longint i = 0; i < n; i++) begin
          shadow_color[i] = {sh_blue, sh_green, sh_red};
          shadow_depth[i] = CLEAR_DEPTH;
        end
      end
      CMD_TRIANGLE: n = raster_tri(c);
      CMD_READ: begin
        if (c.col >= eff_w() || c.row >= eff_h()) begin
          r.outside = 1'b1;
        end else begin
          addr = (eff_h() - 1 - c.row) * eff_w() + c.col;
          r.color = {ALPHA_FF, shadow_color[addr]};
          r.depth = shadow_depth[addr];
        end
      end
      default: ;
    endcase
    if (n > 32767) n = 32767;
    r.count = n[14:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = int'($urandom_range(0, 99));
    if (p < 45) return 0;
    if (p < 85) return int'($urandom_range(1, 3));
    if (p < 97) return int'($urandom_range(4, 15));
    return int'($urandom_range(30, 120));
  endfunction

  function automatic draw_cmd_t mk_cmd(logic [1:0] cmd, int ax, int ay, int az, int bx,
                                      int by, int bz, int cx, int cy, int cz,
                                      int col, int row);
    draw_cmd_t c;
    c.cmd = cmd;
    c.ax = 16'(ax); c.ay = 16'(ay); c.az = 16'(az);
    c.bx = 16'(bx); c.by_coord = 16'(by); c.bz = 16'(bz);
    c.cx = 16'(cx); c.cy = 16'(cy); c.cz = 16'(cz);
    c.col = 7'(col); c.row = 7'(row);
    return c;
  endfunction

  // append one row to the directed table
  function automatic void add_row(draw_cmd_t c, bit typed, pixel_res_t r);
    stim_row_t row;
    row.c = c;
    row.typed = typed;
    row.r = r;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // random command shaped by the current screen size
  function automatic draw_cmd_t rand_cmd();
    draw_cmd_t c;
    int p, w, h, bx, by, sp;
    p = int'($urandom_range(0, 99));
    w = (eff_w() == 0) ? 1 : int'(eff_w());
    h = (eff_h() == 0) ? 1 : int'(eff_h());
    c.cmd = CMD_READ;
    c.ax = rnd16(); c.ay = rnd16(); c.az = rnd16();
    c.bx = rnd16(); c.by_coord = rnd16(); c.bz = rnd16();
    c.cx = rnd16(); c.cy = rnd16(); c.cz = rnd16();
    c.col = 7'($urandom_range(0, 127)); c.row = 7'($urandom_range(0, 127));
    if (p < 6) begin
      c.cmd = CMD_CLEAR;
    end else if (p < 46 || (p < 53 && w * h > 1024)) begin
      // well-formed triangle near the screen
      c.cmd = CMD_TRIANGLE;
      sp = int'($urandom_range(1, 12)) * SUB;
      bx = int'($urandom_range(0, (w + 4) * SUB)) - 2 * SUB;
      by = int'($urandom_range(0, (h + 4) * SUB)) - 2 * SUB;
      c.ax = 16'(bx + int'($urandom_range(0, sp)));
      c.ay = 16'(by + int'($urandom_range(0, sp)));
      c.bx = 16'(bx + int'($urandom_range(0, sp)));
      c.by_coord = 16'(by + int'($urandom_range(0, sp)));
      c.cx = 16'(bx + int'($urandom_range(0, sp)));
      c.cy = 16'(by + int'($urandom_range(0, sp)));
      if ($urandom_range(0, 99) < 80) begin
        c.az = 16'($urandom_range(0, 32767));
        c.bz = 16'($urandom_range(0, 32767));
        c.cz = 16'($urandom_range(0, 32767));
      end
      if ($urandom_range(0, 99) < 5) begin
        c.cx = c.bx;
        c.cy = c.by_coord;
      end
    end else if (p < 53) begin
      // any vertices at all, clipped to a small screen
      c.cmd = CMD_TRIANGLE;
    end else if (p < 95) begin
      if ($urandom_range(0, 3) != 0) begin
        c.col = 7'($urandom_range(0, w - 1));
        c.row = 7'($urandom_range(0, h - 1));
      end
    end else begin
      c.cmd = 2'd3;
    end
    return c;
  endfunction

  // one transfer on the request channel
  task automatic send(draw_cmd_t c, bit typed, pixel_res_t tr);
    int gap;
    pixel_res_t r;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.cmd = c.cmd;
    req_ch.ax = c.ax; req_ch.ay = c.ay; req_ch.az = c.az;
    req_ch.bx = c.bx; req_ch.by_coord = c.by_coord; req_ch.bz = c.bz;
    req_ch.cx = c.cx; req_ch.cy = c.cy; req_ch.cz = c.cz;
    req_ch.read_column = c.col; req_ch.read_row = c.row;
    req_ch.valid = 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    r = fb_apply(c);
    pending_px.insert(pending_px.size(), typed ? tr : r);
    @(negedge clk);
  endtask

  task automatic drain();
    req_ch.valid = 1'b0;
    while (pending_px.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    case (idx)
      REG_WIDTH:  sh_width = val;
      REG_HEIGHT: sh_height = val;
      REG_RED:    sh_red = val;
      REG_GREEN:  sh_green = val;
      REG_BLUE:   sh_blue = val;
      default: ;
    endcase
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  // response side: random ready, with one long hold-off
  initial begin
    int rgap;
    rgap = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        rsp_ch.ready = 1'b0;
        hold_len--;
      end else if (rgap > 0) begin
        rsp_ch.ready = 1'b0;
        rgap--;
      end else begin
        rsp_ch.ready = 1'b1;
        rgap = calm ? 0 : pick_gap();
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    pixel_res_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_px.size() == 0) begin
        $display("%t: unexpected result colour %h depth %h count %0d outside %b", $time,
                 rsp_ch.pixel_color, rsp_ch.pixel_depth, rsp_ch.pixels_written,
                 rsp_ch.read_outside);
        errors++;
      end else begin
        e = pending_px.pop_front();
        if (rsp_ch.pixel_color !== e.color) begin
          $display("%t: pixel_color exp %h got %h", $time, e.color, rsp_ch.pixel_color);
          errors++;
        end
        if (rsp_ch.pixel_depth !== e.depth) begin
          $display("%t: pixel_depth exp %h got %h", $time, e.depth, rsp_ch.pixel_depth);
          errors++;
        end
        if (rsp_ch.pixels_written !== e.count) begin
          $display("%t: pixels_written exp %0d got %0d", $time, e.count,
                   rsp_ch.pixels_written);
          errors++;
        end
        if (rsp_ch.read_outside !== e.outside) begin
          $display("%t: read_outside exp %b got %b", $time, e.outside, rsp_ch.read_outside);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    pixel_res_t none, read_clr;
    int         phase_cfg[9][5];
    int         n_items;
    errors = 0;
    hold_len = 0;
    calm = 1'b0;
    rst = 1'b1;
    wr_en = 1'b0; wr_index = '0; wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_CLEAR;
    req_ch.ax = '0; req_ch.ay = '0; req_ch.az = '0;
    req_ch.bx = '0; req_ch.by_coord = '0; req_ch.bz = '0;
    req_ch.cx = '0; req_ch.cy = '0; req_ch.cz = '0;
    req_ch.read_column = '0; req_ch.read_row = '0;
    sh_width = SIZE_RESET; sh_height = SIZE_RESET;
    sh_red = '0; sh_green = '0; sh_blue = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    none = '{default: '0};
    read_clr = '{color: 32'hFF000000, depth: CLEAR_DEPTH, count: '0, outside: 1'b0};

    // directed table at reset size; the first clear covers the whole store
    add_row(mk_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            '{color: '0, depth: '0, count: 15'd16384, outside: 1'b0});
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, read_clr);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 127, 127), 1, read_clr);
    add_row(mk_cmd(2'd3, -1, -1, -1, -1, -1, -1, -1, -1, -1, 127, 127), 1, none);
    add_row(mk_cmd(CMD_TRIANGLE, 16, 16, 256, 160, 16, 256, 16, 160, 256, 0, 0), 0, none);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 2, 2), 0, none);
    // zero area: collinear vertices
    add_row(mk_cmd(CMD_TRIANGLE, 0, 0, 256, 64, 64, 256, 128, 128, 256, 0, 0), 1, none);
    // negative depth everywhere: nothing written
    add_row(mk_cmd(CMD_TRIANGLE, 32, 32, -256, 200, 40, -256, 40, 200, -256, 0, 0), 1,
            none);
    // clockwise winding, depth extremes
    add_row(mk_cmd(CMD_TRIANGLE, 300, 300, 32767, 300, 500, -32768, 500, 300, 32767,
                   0, 0), 0, none);
    add_row(mk_cmd(CMD_TRIANGLE, 600, 40, 32767, 800, 40, 32767, 700, 240, 32767, 0, 0),
            0, none);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 20, 20), 0, none);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 40, 5), 0, none);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 127, 0), 1, read_clr);
    foreach (dir_rows[i]) send(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);

    // random phases: width, height, red, green, blue
    phase_cfg = '{'{16, 16, 255, 0, 128}, '{1, 1, 0, 255, 0}, '{0, 9, 17, 34, 51},
                  '{200, 8, 170, 85, 240}, '{32, 24, 1, 2, 3}, '{255, 0, 9, 9, 9},
                  '{9, 33, 0, 0, 255}, '{128, 1, 66, 77, 88}, '{128, 128, 255, 255, 255}};
    foreach (phase_cfg[ph]) begin
      drain();
      write_reg(REG_WIDTH, 8'(phase_cfg[ph][0]));
      write_reg(REG_HEIGHT, 8'(phase_cfg[ph][1]));
      write_reg(REG_RED, 8'(phase_cfg[ph][2]));
      write_reg(REG_GREEN, 8'(phase_cfg[ph][3]));
      write_reg(REG_BLUE, 8'(phase_cfg[ph][4]));
      if (ph == 2) write_reg(3'd7, 8'hA5);  // unknown index, ignored
      n_items = (ph == 8) ? 90 : 165;
      if (ph == 0) hold_len = 600;
      for (int k = 0; k < n_items; k++) begin
        if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        send(rand_cmd(), 0, none);
      end
      calm = 1'b0;
    end

    // wind down
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/tff_pkg.sv
design/tff_req_if.sv
design/tff_rsp_if.sv
design/tff_alu.sv
design/triangle_fill_framebuffer.sv
tb/tb.sv
